>>> rtl/core/bal_pkg.sv
// Shared types and constants for the bounded array list unit.
`timescale 1ns / 1ps

package bal_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W = 8;
   localparam int CNT_W = 9;
   localparam int IDX_W = 4;

   localparam logic [2:0] FUNC_FRONT = 3'd0;
   localparam logic [2:0] FUNC_APPEND = 3'd1;
   localparam logic [2:0] FUNC_BEFORE = 3'd2;
   localparam logic [2:0] FUNC_AFTER = 3'd3;
   localparam logic [2:0] FUNC_SEARCH = 3'd4;
   localparam logic [2:0] FUNC_READ = 3'd5;

   typedef struct packed {
      logic [DATA_W-1:0] operand;
      logic [DATA_W-1:0] value;
      logic [IDX_W-1:0]  index;
      logic [CNT_W-1:0]  count;
      logic              shift_en;
      logic [POS_W-1:0]  ins_pos;
   } cell_ctl_type;

   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] data;
   } scan_type;

endpackage

>>> rtl/core/bal_cell.sv
// One list cell: holds an entry, joins the scan wave and shifts on insert.
`timescale 1ns / 1ps

module bal_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                       clock,
   input  logic [bal_pkg::DATA_W-1:0] left_entry,
   output logic [bal_pkg::DATA_W-1:0] entry_out,
   input  bal_pkg::cell_ctl_type      ctl,
   input  bal_pkg::scan_type          carry_in,
   output bal_pkg::scan_type          carry_out
);

   localparam logic [bal_pkg::POS_W-1:0] MY_POS = bal_pkg::POS_W'(CELL_IDX);
   localparam logic [bal_pkg::CNT_W-1:0] MY_CNT = bal_pkg::CNT_W'(CELL_IDX);

   logic [bal_pkg::DATA_W-1:0] entry_ff;
   logic [bal_pkg::DATA_W-1:0] entry_in;
   bal_pkg::scan_type          carry_ff;
   bal_pkg::scan_type          carry_in_next;
   logic                       match;

   always_comb begin
      match = (MY_CNT < ctl.count) && (entry_ff == ctl.operand);
      carry_in_next.found = carry_in.found | match;
      carry_in_next.pos = (match && !carry_in.found) ? MY_POS : carry_in.pos;
      carry_in_next.data = (bal_pkg::POS_W'(ctl.index) == MY_POS) ? entry_ff : carry_in.data;
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift_en) begin
         priority if (MY_POS == ctl.ins_pos) begin
            entry_in = ctl.value;
         end else if ((MY_POS > ctl.ins_pos) && (MY_CNT <= ctl.count)) begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      carry_ff <= carry_in_next;
   end

   assign entry_out = entry_ff;
   assign carry_out = carry_ff;

endmodule

>>> rtl/core/bounded_array_list_unit.sv
// Top level of the bounded array list unit: controller and row of list cells.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries held in a row of cells.
// One item is handled at a time: the item is latched on acceptance, the
// compare and read wave then passes through the registered cell row in the
// scan state, and a commit state loads the result and shifts the cells for
// an insert; the commit waits while an earlier result is still not taken.
// The result register lets the next item be accepted while the previous
// result still waits to be taken. Entries need no clearing after reset;
// only entries below the count are ever examined.
module bounded_array_list_unit #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // func[2:0], key[34:3], value[66:35], index[70:67]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // ok[0], position[4:1], read_data[36:5], count[41:37]
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;
   localparam int SCAN_W = $clog2(CAPACITY + 1);
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(CAPACITY - 1);
   localparam logic [bal_pkg::CNT_W-1:0] FULL_CNT = bal_pkg::CNT_W'(CAPACITY);

   logic [1:0]                 state_ff, state_in;
   logic [SCAN_W-1:0]          scan_cnt_ff, scan_cnt_in;
   logic [bal_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [2:0]                 func_ff;
   logic [bal_pkg::DATA_W-1:0] operand_ff;
   logic [bal_pkg::DATA_W-1:0] value_ff;
   logic [bal_pkg::IDX_W-1:0]  index_ff;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0]                rsp_tdata_ff, rsp_tdata_in;

   logic [2:0]                 req_func;
   logic [bal_pkg::DATA_W-1:0] req_key;
   logic [bal_pkg::DATA_W-1:0] req_value;
   logic [bal_pkg::IDX_W-1:0]  req_index;
   logic                       accept;
   logic                       commit;
   logic                       full;
   logic                       res_ok;
   logic [bal_pkg::POS_W-1:0]  res_pos;
   logic [bal_pkg::DATA_W-1:0] res_data;
   logic                       do_insert;
   logic [bal_pkg::POS_W-1:0]  ins_pos;

   bal_pkg::cell_ctl_type      ctl;
   bal_pkg::scan_type          carry [CAPACITY];
   bal_pkg::scan_type          tail;
   logic [bal_pkg::DATA_W-1:0] entry [CAPACITY];

   assign req_func = req_tdata[2:0];
   assign req_key = req_tdata[34:3];
   assign req_value = req_tdata[66:35];
   assign req_index = req_tdata[70:67];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign commit = (state_ff == ST_COMMIT) && (!rsp_tvalid_ff || rsp_tready);
   assign full = (count_ff == FULL_CNT);
   assign tail = carry[CAPACITY-1];

   always_comb begin
      res_ok = 1'b0;
      res_pos = '0;
      res_data = '0;
      do_insert = 1'b0;
      ins_pos = '0;
      unique case (func_ff)
         bal_pkg::FUNC_FRONT: begin
            do_insert = !full;
         end
         bal_pkg::FUNC_APPEND: begin
            do_insert = !full;
            ins_pos = count_ff[bal_pkg::POS_W-1:0];
         end
         bal_pkg::FUNC_BEFORE: begin
            do_insert = !full && tail.found;
            ins_pos = tail.pos;
         end
         bal_pkg::FUNC_AFTER: begin
            do_insert = !full && tail.found;
            ins_pos = tail.pos + 1'b1;
         end
         bal_pkg::FUNC_SEARCH: begin
            res_ok = tail.found;
            res_pos = tail.found ? tail.pos : '0;
            res_data = tail.found ? '0 : '1;
         end
         bal_pkg::FUNC_READ: begin
            res_ok = (bal_pkg::CNT_W'(index_ff) < count_ff);
            res_data = res_ok ? tail.data : '1;
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase
      if (do_insert) begin
         res_ok = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      scan_cnt_in = scan_cnt_ff;
      count_in = count_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in = rsp_tdata_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               scan_cnt_in = SCAN_LAST;
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == '0) begin
               state_in = ST_COMMIT;
            end else begin
               scan_cnt_in = scan_cnt_ff - 1'b1;
            end
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in = ST_IDLE;
               if (do_insert) begin
                  count_in = count_ff + 1'b1;
               end
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in = {6'd0, count_in[4:0], res_data, res_pos[3:0], res_ok};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_cnt_ff <= '0;
         count_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         count_ff <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      if (accept) begin
         func_ff <= req_func;
         operand_ff <= ((req_func == bal_pkg::FUNC_BEFORE) || (req_func == bal_pkg::FUNC_AFTER))
                       ? req_key : req_value;
         value_ff <= req_value;
         index_ff <= req_index;
      end
   end

   always_comb begin
      ctl.operand = operand_ff;
      ctl.value = value_ff;
      ctl.index = index_ff;
      ctl.count = count_ff;
      ctl.shift_en = commit && do_insert;
      ctl.ins_pos = ins_pos;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      bal_pkg::scan_type          cin;
      logic [bal_pkg::DATA_W-1:0] left;
      if (i == 0) begin : g_head
         assign cin = '0;
         assign left = value_ff;
      end else begin : g_body
         assign cin = carry[i-1];
         assign left = entry[i-1];
      end
      bal_cell #(
         .CELL_IDX(i)
      ) u_cell (
         .clock(clock),
         .left_entry(left),
         .entry_out(entry[i]),
         .ctl(ctl),
         .carry_in(cin),
         .carry_out(carry[i])
      );
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

endmodule

>>> rtl/core/bal_checker.sv
// Port-level checks for the bounded array list unit, bound to the top level.
`timescale 1ns / 1ps

module bal_checker #(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result changed while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second item taken while one is in progress.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[41:37]) <= CAPACITY))
      else $error("Reported count exceeds capacity.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[4:1] != 4'd0) |-> rsp_tdata[0])
      else $error("Nonzero position on a failed operation.");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result shown right after reset.");

endmodule

bind bounded_array_list_unit bal_checker #(
   .CAPACITY(CAPACITY)
) u_bal_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
